// ----- rtl/core/periodic_interrupt_ack_latency_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the periodic interrupt acknowledge latency unit
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_INTERRUPT_ACK_LATENCY_UNIT_MACROS_SVH
`define PERIODIC_INTERRUPT_ACK_LATENCY_UNIT_MACROS_SVH

// Consequent checked in the same cycle.
`define PIAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the next cycle.
`define PIAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pial_pkg.sv -----
// ----------------------------------------------------------------------------
// pial_pkg
// Widths, codes, register indexes and reset values shared by the interrupt ack latency unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pial_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    localparam int S_DATA_WIDTH = 16;
    localparam int M_DATA_WIDTH = 168;

    // input word modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_ACK   = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    // run status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_ACK   = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PERIOD       = 2'd0;
    localparam logic [1:0] CFG_TOTAL        = 2'd1;
    localparam logic [1:0] CFG_ACK_CODE     = 2'd2;
    localparam logic [1:0] CFG_INVALID_TIME = 2'd3;

    localparam logic [31:0] PERIOD_RESET       = 32'd100000;
    localparam logic [31:0] INVALID_TIME_RESET = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ----- rtl/core/periodic_interrupt_ack_latency_unit.sv -----
// ----------------------------------------------------------------------------
// periodic_interrupt_ack_latency_unit
// Words pass the input, process, latency and output stages, one per cycle
// while m_tready does not stall the output; state is updated in the single
// process stage, and one 32x32 multiplier forms the late latency product in
// the latency stage. Reset: synchronous, active low; line released, run idle,
// counters cleared, configuration registers back to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_interrupt_ack_latency_unit_macros.svh"

module periodic_interrupt_ack_latency_unit
    import pial_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    cfg_wr_en,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [31:0]             cfg_data,

    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // [1:0] mode, [9:2] command_byte, [15:10] zero
    input  wire logic [S_DATA_WIDTH-1:0] s_tdata,

    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // [0] irq_line, [1] ack_valid, [33:2] time_since_edge, [65:34] check_word,
    // [66] done_res, [68:67] run_status, [100:69] before_deadline_total,
    // [132:101] after_deadline_total, [164:133] repeat_ack_total, [167:165] zero
    output logic [M_DATA_WIDTH-1:0]      m_tdata
);

    // configuration
    logic [31:0] period_reg;
    logic [31:0] total_reg;
    logic [7:0]  ack_code_reg;
    logic [31:0] invalid_time_reg;

    // run state
    logic [COUNT_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [31:0] last_acked_reg, last_acked_next;
    logic [31:0] before_reg, before_next;
    logic [31:0] after_reg, after_next;
    logic [31:0] repeat_reg, repeat_next;
    logic [1:0]  status_reg, status_next;
    logic        line_level_reg, line_level_next;
    logic        active_reg, active_next;

    // input stage
    logic        v1_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  cmd_reg;

    // latency stage
    logic        v2_reg;
    logic        s2_line_reg, s2_line_next;
    logic        s2_ack_reg, s2_ack_next;
    logic        s2_late_reg, s2_late_next;
    logic [31:0] s2_base_reg, s2_base_next;
    logic [31:0] s2_mul_a_reg, s2_mul_a_next;
    logic [31:0] s2_period_reg;
    logic        s2_done_reg, s2_done_next;
    logic [1:0]  s2_status_reg;
    logic [31:0] s2_before_reg;
    logic [31:0] s2_after_reg;
    logic [31:0] s2_repeat_reg;

    // output stage
    logic        m_valid_reg;
    logic [M_DATA_WIDTH-1:0] m_data_reg, m_data_next;

    logic rdy_out, rdy2, rdy1, adv1;

    assign rdy_out  = !m_valid_reg || m_tready;
    assign rdy2     = !v2_reg || rdy_out;
    assign rdy1     = !v1_reg || rdy2;
    assign adv1     = v1_reg && rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg       <= PERIOD_RESET;
            total_reg        <= '0;
            ack_code_reg     <= '0;
            invalid_time_reg <= INVALID_TIME_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PERIOD:       period_reg       <= cfg_data;
                CFG_TOTAL:        total_reg        <= cfg_data;
                CFG_ACK_CODE:     ack_code_reg     <= cfg_data[7:0];
                CFG_INVALID_TIME: invalid_time_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- process stage ----------------
    logic [31:0]            period_eff;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic [CMP_WIDTH-1:0]   tick_ext;
    logic [31:0]            capture;
    logic [31:0]            diff;

    assign period_eff = (period_reg == '0) ? 32'd1 : period_reg;
    assign tick_inc   = tick_count_reg + COUNT_WIDTH'(1);
    assign tick_ext   = CMP_WIDTH'(tick_count_reg);
    assign capture    = tick_ext[31:0];
    assign diff       = last_acked_reg - remaining_reg;

    always_comb begin
        tick_count_next = tick_count_reg;
        remaining_next  = remaining_reg;
        last_acked_next = last_acked_reg;
        before_next     = before_reg;
        after_next      = after_reg;
        repeat_next     = repeat_reg;
        status_next     = status_reg;
        line_level_next = line_level_reg;
        active_next     = active_reg;
        s2_ack_next     = 1'b0;
        s2_late_next    = 1'b0;
        s2_base_next    = '0;
        s2_mul_a_next   = diff - 32'd1;
        s2_done_next    = 1'b0;

        case (mode_reg)
            MODE_START: begin
                remaining_next  = total_reg;
                last_acked_next = total_reg;
                before_next     = '0;
                after_next      = '0;
                repeat_next     = '0;
                status_next     = STATUS_OK;
                tick_count_next = '0;
                line_level_next = 1'b1;
                active_next     = (total_reg != '0);
                s2_done_next    = (total_reg == '0);
            end
            MODE_TICK: begin
                if (active_reg) begin
                    if (remaining_reg != '0
                        && CMP_WIDTH'(tick_inc) == CMP_WIDTH'(period_eff)) begin
                        tick_count_next = '0;
                        line_level_next = 1'b0;
                        remaining_next  = remaining_reg - 32'd1;
                    end else begin
                        tick_count_next = tick_inc;
                    end
                end
            end
            MODE_ACK: begin
                if (active_reg) begin
                    line_level_next = 1'b1;
                    if (cmd_reg != ack_code_reg) begin
                        status_next  = STATUS_NO_ACK;
                        active_next  = 1'b0;
                        s2_done_next = 1'b1;
                    end else if (diff[31]) begin
                        status_next  = STATUS_OVERFLOW;
                        active_next  = 1'b0;
                        s2_done_next = 1'b1;
                    end else begin
                        if (diff == '0) begin
                            repeat_next  = repeat_reg + 32'd1;
                            s2_base_next = invalid_time_reg;
                        end else if (diff == 32'd1) begin
                            before_next  = before_reg + 32'd1;
                            s2_base_next = capture;
                        end else begin
                            after_next   = after_reg + 32'd1;
                            s2_base_next = capture;
                            s2_late_next = 1'b1;
                        end
                        last_acked_next = remaining_reg;
                        s2_ack_next     = 1'b1;
                        if (remaining_reg == '0) begin
                            status_next  = STATUS_OK;
                            active_next  = 1'b0;
                            s2_done_next = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        s2_line_next = line_level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            tick_count_reg <= '0;
            remaining_reg  <= '0;
            last_acked_reg <= '0;
            before_reg     <= '0;
            after_reg      <= '0;
            repeat_reg     <= '0;
            status_reg     <= STATUS_OK;
            line_level_reg <= 1'b1;
            active_reg     <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (adv1) begin
                tick_count_reg <= tick_count_next;
                remaining_reg  <= remaining_next;
                last_acked_reg <= last_acked_next;
                before_reg     <= before_next;
                after_reg      <= after_next;
                repeat_reg     <= repeat_next;
                status_reg     <= status_next;
                line_level_reg <= line_level_next;
                active_reg     <= active_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            mode_reg <= s_tdata[1:0];
            cmd_reg  <= s_tdata[9:2];
        end
    end

    // ---------------- latency stage ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s2_line_reg   <= s2_line_next;
            s2_ack_reg    <= s2_ack_next;
            s2_late_reg   <= s2_late_next;
            s2_base_reg   <= s2_base_next;
            s2_mul_a_reg  <= s2_mul_a_next;
            s2_period_reg <= period_reg;
            s2_done_reg   <= s2_done_next;
            s2_status_reg <= status_next;
            s2_before_reg <= before_next;
            s2_after_reg  <= after_next;
            s2_repeat_reg <= repeat_next;
        end
    end

    logic [63:0] late_prod;
    logic [31:0] time_val;
    logic [31:0] check_val;

    assign late_prod = s2_mul_a_reg * s2_period_reg;
    assign time_val  = s2_late_reg ? (late_prod[31:0] + s2_base_reg) : s2_base_reg;
    assign check_val = s2_ack_reg ? ~time_val : 32'd0;

    always_comb begin
        m_data_next          = '0;
        m_data_next[0]       = s2_line_reg;
        m_data_next[1]       = s2_ack_reg;
        m_data_next[33:2]    = time_val;
        m_data_next[65:34]   = check_val;
        m_data_next[66]      = s2_done_reg;
        m_data_next[68:67]   = s2_status_reg;
        m_data_next[100:69]  = s2_before_reg;
        m_data_next[132:101] = s2_after_reg;
        m_data_next[164:133] = s2_repeat_reg;
    end

    // ---------------- output stage ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy_out) begin
            m_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_out && v2_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    // ---------------- assertions ----------------
    `PIAL_ASSERT_NOW(a_idle_line_released, !active_reg, line_level_reg,
        "line asserted while no run is active")
    `PIAL_ASSERT_NOW(a_no_ack_zero_time, m_tvalid && !m_tdata[1],
        m_tdata[65:2] == 64'd0, "time or check word set without acknowledge")
    `PIAL_ASSERT_NOW(a_done_releases_line, m_tvalid && m_tdata[66], m_tdata[0],
        "run ended with the line still asserted")
    `PIAL_ASSERT_NOW(a_no_ack_end_silent,
        m_tvalid && m_tdata[66] && m_tdata[68:67] == STATUS_NO_ACK, !m_tdata[1],
        "wrong command byte produced an acknowledge response")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the periodic interrupt acknowledge latency unit.
// A word queue feeds a stream driver, and a word-level model of the timer
// predicts one response per accepted word. The monitor compares each response
// field by field. Both sides insert random gaps, and the configuration is
// rewritten between phases while nothing is in flight.
// ----------------------------------------------------------------------------
module tb;
    import pial_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_PHASES   = 12;
    localparam int WORDS_PER_PHASE = 92;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] ticks;
        logic [31:0]            remaining;
        logic [31:0]            acked_mark;
        logic [31:0]            on_time;
        logic [31:0]            late;
        logic [31:0]            repeats;
        logic [1:0]             status;
        logic                   line;
        logic                   running;
    } timer_state_t;

    typedef struct packed {
        logic        irq_line;
        logic        ack_valid;
        logic [31:0] latency;
        logic [31:0] check;
        logic        done;
        logic [1:0]  status;
        logic [31:0] on_time;
        logic [31:0] late;
        logic [31:0] repeats;
    } response_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [1:0]              cfg_index = CFG_PERIOD;
    logic [31:0]             cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_DATA_WIDTH-1:0] s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_DATA_WIDTH-1:0] m_tdata;

    // register mirrors, updated once the writes have landed
    logic [31:0] period_reg   = PERIOD_RESET;
    logic [31:0] total_reg    = '0;
    logic [7:0]  ack_code_reg = '0;
    logic [31:0] invalid_reg  = INVALID_TIME_RESET;

    timer_state_t            timer_st = '{line: 1'b1, default: '0};
    logic [S_DATA_WIDTH-1:0] word_q[$];
    response_t               response_q[$];

    int pending_words = 0;
    int src_pct       = 0;
    int sink_pct      = 0;
    int src_wait      = 0;
    int sink_wait     = 0;
    int mismatches    = 0;
    int checked       = 0;
    int acks_timed    = 0;
    int runs_ended    = 0;
    int bad_commands  = 0;
    int cycle_count   = 0;

    periodic_interrupt_ack_latency_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     pending_words);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Advance the timer by one word and return the response it produces.
    function automatic response_t advance_timer(inout timer_state_t st,
                                                input logic [1:0] mode,
                                                input logic [7:0] cmd);
        response_t   r;
        logic [63:0] wide_ticks;
        logic [63:0] eff_period;
        logic [31:0] capture;
        logic [31:0] span;
        r          = '0;
        wide_ticks = '0;
        if (mode == MODE_START) begin
            st.remaining  = total_reg;
            st.acked_mark = total_reg;
            st.on_time    = '0;
            st.late       = '0;
            st.repeats    = '0;
            st.status     = STATUS_OK;
            st.ticks      = '0;
            st.line       = 1'b1;
            st.running    = (total_reg != 0);
            r.done        = !st.running;
        end else if (mode == MODE_TICK && st.running) begin
            eff_period = (period_reg == 0) ? 64'd1 : {32'd0, period_reg};
            st.ticks   = st.ticks + 1'b1;
            wide_ticks[COUNT_WIDTH-1:0] = st.ticks;
            // no interrupts left: counter runs free
            if (st.remaining != 0 && wide_ticks == eff_period) begin
                st.ticks     = '0;
                st.line      = 1'b0;
                st.remaining = st.remaining - 1;
            end
        end else if (mode == MODE_ACK && st.running) begin
            wide_ticks[COUNT_WIDTH-1:0] = st.ticks;
            capture = wide_ticks[31:0];
            st.line = 1'b1;
            if (cmd != ack_code_reg) begin
                st.status  = STATUS_NO_ACK;
                st.running = 1'b0;
                r.done     = 1'b1;
            end else begin
                span = st.acked_mark - st.remaining;
                if (span[31]) begin
                    st.status  = STATUS_OVERFLOW;
                    st.running = 1'b0;
                    r.done     = 1'b1;
                end else begin
                    if (span == 0) begin
                        st.repeats = st.repeats + 1;
                        r.latency  = invalid_reg;
                    end else if (span == 1) begin
                        st.on_time = st.on_time + 1;
                        r.latency  = capture;
                    end else begin
                        st.late   = st.late + 1;
                        r.latency = (span - 32'd1) * period_reg + capture;
                    end
                    st.acked_mark = st.remaining;
                    r.ack_valid   = 1'b1;
                    r.check       = ~r.latency;
                    if (st.remaining == 0) begin
                        st.status  = STATUS_OK;
                        st.running = 1'b0;
                        r.done     = 1'b1;
                    end
                end
            end
        end
        r.irq_line = st.line;
        r.status   = st.status;
        r.on_time  = st.on_time;
        r.late     = st.late;
        r.repeats  = st.repeats;
        return r;
    endfunction

    function automatic int next_gap(input int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        if (mismatches <= 30)
            $display("mismatch at word %0d: %s got %h want %h", checked, what, got, want);
    endtask

    task automatic check_response(input logic [M_DATA_WIDTH-1:0] w);
        response_t want;
        if (response_q.size() == 0) begin
            report("response with nothing pending", w[31:0], '0);
        end else begin
            want = response_q.pop_front();
            checked++;
            pending_words--;
            if (want.ack_valid) acks_timed++;
            if (want.done) runs_ended++;
            if (want.done && want.status == STATUS_NO_ACK) bad_commands++;
            if (w[0] !== want.irq_line)
                report("irq_line", 32'(w[0]), 32'(want.irq_line));
            if (w[1] !== want.ack_valid)
                report("ack_valid", 32'(w[1]), 32'(want.ack_valid));
            if (w[33:2] !== want.latency) report("time_since_edge", w[33:2], want.latency);
            if (w[65:34] !== want.check) report("check_word", w[65:34], want.check);
            if (w[66] !== want.done) report("done_res", 32'(w[66]), 32'(want.done));
            if (w[68:67] !== want.status)
                report("run_status", 32'(w[68:67]), 32'(want.status));
            if (w[100:69] !== want.on_time)
                report("before_deadline_total", w[100:69], want.on_time);
            if (w[132:101] !== want.late) report("after_deadline_total", w[132:101], want.late);
            if (w[164:133] !== want.repeats) report("repeat_ack_total", w[164:133], want.repeats);
        end
    endtask

    // driver: predict at acceptance, then load the next word unless a gap is due
    always @(posedge aclk) begin
        response_t resp;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                resp = advance_timer(timer_st, s_tdata[1:0], s_tdata[9:2]);
                response_q.push_back(resp);
            end
            if (!s_tvalid || s_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end else if (word_q.size() != 0) begin
                    s_tdata  <= word_q.pop_front();
                    s_tvalid <= 1'b1;
                    src_wait = next_gap(src_pct);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_response(m_tdata);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_wait = next_gap(sink_pct);
            end
        end
    end

    task automatic push_word(input logic [1:0] mode, input logic [7:0] cmd);
        logic [S_DATA_WIDTH-1:0] w;
        w       = '0;
        w[1:0]  = mode;
        w[9:2]  = cmd;
        pending_words++;
        word_q.push_back(w);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic set_config(input logic [31:0] period, input logic [31:0] total,
                              input logic [7:0] code, input logic [31:0] invalid);
        write_reg(CFG_PERIOD, period);
        write_reg(CFG_TOTAL, total);
        write_reg(CFG_ACK_CODE, {24'd0, code});
        write_reg(CFG_INVALID_TIME, invalid);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        period_reg   = period;
        total_reg    = total;
        ack_code_reg = code;
        invalid_reg  = invalid;
    endtask

    task automatic wait_idle();
        while (pending_words != 0) @(posedge aclk);
        // drain margin beyond the pipeline
        repeat (6) @(posedge aclk);
    endtask

    // Mostly well-formed runs: starts, ticks and matching acks; a little noise.
    task automatic queue_phase(input int target);
        timer_state_t st;
        response_t    unused;
        int           counted;
        int           pick;
        logic [1:0]   mode;
        logic [7:0]   cmd;
        st      = timer_st;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(0, 99);
            cmd  = ack_code_reg;
            if (st.running) begin
                if (pick < 3) begin
                    mode = MODE_UNUSED;
                end else if (pick < 6) begin
                    mode = MODE_START;
                end else if (pick < 9) begin
                    mode = MODE_ACK;
                    cmd  = 8'($urandom_range(1, 255));
                    cmd  = cmd ^ ack_code_reg;
                end else if (pick < 30) begin
                    mode = MODE_ACK;
                end else begin
                    mode = MODE_TICK;
                end
                if (mode != MODE_UNUSED) counted++;
            end else if (pick < 70) begin
                mode = MODE_START;
                counted++;
            end else begin
                mode = 2'($urandom_range(0, 3));
                cmd  = 8'($urandom_range(0, 255));
                if (mode == MODE_START) counted++;
            end
            unused = advance_timer(st, mode, cmd);
            push_word(mode, cmd);
        end
    endtask

    initial begin
        logic [31:0] period;
        logic [31:0] total;
        logic [31:0] invalid;
        logic [7:0]  code;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        src_pct  = 20;
        sink_pct = 20;
        // period zero behaves as one: repeat, on-time and late acks, then a bad command
        set_config(32'd0, 32'd3, 8'hA5, 32'd0);
        push_word(MODE_TICK, 8'h00);
        push_word(MODE_UNUSED, 8'hFF);
        push_word(MODE_START, 8'h00);
        push_word(MODE_ACK, 8'hA5);
        push_word(MODE_TICK, 8'h00);
        push_word(MODE_ACK, 8'hA5);
        repeat (4) push_word(MODE_TICK, 8'h00);
        push_word(MODE_ACK, 8'hA5);
        push_word(MODE_START, 8'h00);
        push_word(MODE_ACK, 8'h5A);
        wait_idle();

        // zero total ends at once; full-scale total with a restart mid-run
        set_config(32'hFFFF_FFFF, 32'd0, 8'hFF, 32'hFFFF_FFFF);
        push_word(MODE_START, 8'h00);
        push_word(MODE_ACK, 8'hFF);
        wait_idle();
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        push_word(MODE_START, 8'h00);
        push_word(MODE_TICK, 8'h00);
        push_word(MODE_ACK, 8'hFF);
        push_word(MODE_START, 8'h00);
        push_word(MODE_ACK, 8'h00);
        wait_idle();

        // two periods elapse before the ack: late by one period plus the capture
        set_config(32'd3, 32'd4, 8'h00, 32'h1234_5678);
        push_word(MODE_START, 8'h00);
        repeat (7) push_word(MODE_TICK, 8'h00);
        push_word(MODE_ACK, 8'h00);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0:       period = 32'd0;
                1:       period = 32'd1;
                8:       period = 32'hFFFF_FFFF;
                9:       period = $urandom();
                default: period = $urandom_range(2, 6);
            endcase
            case ($urandom_range(0, 9))
                0:       total = 32'd0;
                1:       total = 32'hFFFF_FFFF;
                default: total = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 3))
                0:       code = 8'h00;
                1:       code = 8'hFF;
                default: code = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 3))
                0:       invalid = 32'd0;
                1:       invalid = 32'hFFFF_FFFF;
                default: invalid = $urandom();
            endcase
            case ($urandom_range(0, 2))
                0:       src_pct = 0;
                1:       src_pct = 15;
                default: src_pct = 50;
            endcase
            case ($urandom_range(0, 2))
                0:       sink_pct = 0;
                1:       sink_pct = 15;
                default: sink_pct = 50;
            endcase
            // the run may carry over, so a late ack can meet a new, large period
            set_config(period, total, code, invalid);
            queue_phase(WORDS_PER_PHASE);
            wait_idle();
        end

        if (response_q.size() != 0)
            report("responses never delivered", response_q.size(), '0);
        $display("checked %0d response words, %0d of them timed acknowledges",
                 checked, acks_timed);
        $display("%0d runs ended, %0d of them on a wrong command byte", runs_ended,
                 bad_commands);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
